// ===== design/chse_pkg.sv =====
// ----------------------------------------------------------------------------
// chse_pkg
// shared types and constants for the order-1 context huffman encoder
// ----------------------------------------------------------------------------
package chse_pkg;

  localparam int NumSymbolsDef    = 256;
  localparam int NodesPerTreeDef  = 512;
  localparam int MaxStringBytesDef = 255;

  localparam int          LinkW    = 10;
  localparam logic [8:0]  NoParent = 9'h1FF;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpEncode = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] ctx;
    logic [8:0] node_index;
    logic [8:0] parent_index;
    logic       right_child;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic [7:0] string_bytes;
    logic       overflow;
  } out_item_t;

  typedef struct packed {
    logic bit_vld;
    logic bit_val;
    logic flush;
  } pk_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_POP,
    ST_FLUSH
  } state_e;

endpackage

// ===== design/chse_link_mem.sv =====
// ----------------------------------------------------------------------------
// chse_link_mem
// tree link storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module chse_link_mem #(
  parameter int Depth = chse_pkg::NumSymbolsDef * chse_pkg::NodesPerTreeDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [chse_pkg::LinkW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [chse_pkg::LinkW-1:0] rdata_o
);
  import chse_pkg::*;

  logic [LinkW-1:0] mem [Depth];
  logic [LinkW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/chse_packer.sv =====
// ----------------------------------------------------------------------------
// chse_packer
// packs code bits lsb first into bytes, counts string bytes, output register
// ----------------------------------------------------------------------------
module chse_packer #(
  parameter int MAX_STRING_BYTES = chse_pkg::MaxStringBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chse_pkg::pk_req_t   req_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output chse_pkg::out_item_t out_data_o
);
  import chse_pkg::*;

  localparam logic [7:0] MaxB = 8'(MAX_STRING_BYTES);

  logic [7:0] acc_q, acc_d;
  logic [2:0] pend_q, pend_d;
  logic [7:0] cnt_q, cnt_d;
  logic       ovf_q, ovf_d;
  logic       out_vld_q, out_vld_d;
  out_item_t  out_q, out_d;

  logic       room;
  logic [7:0] acc_bit;
  logic [7:0] cnt_inc;
  logic       ovf_inc;

  always_comb begin
    room      = !out_vld_q || out_ready_i;
    acc_bit   = acc_q | (8'(req_i.bit_val) << pend_q);
    if (cnt_q >= MaxB) begin
      cnt_inc = cnt_q;
      ovf_inc = 1'b1;
    end else begin
      cnt_inc = cnt_q + 8'd1;
      ovf_inc = ovf_q;
    end
    acc_d     = acc_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    priority if (room && req_i.bit_vld) begin
      if (pend_q == 3'd7) begin
        cnt_d     = cnt_inc;
        ovf_d     = ovf_inc;
        out_d     = '{data_byte: acc_bit, byte_valid: 1'b1, end_of_string: 1'b0,
                      string_bytes: 8'd0, overflow: 1'b0};
        out_vld_d = 1'b1;
        acc_d     = '0;
        pend_d    = '0;
      end else begin
        acc_d  = acc_bit;
        pend_d = pend_q + 3'd1;
      end
    end else if (room && req_i.flush) begin
      if (pend_q != 3'd0) begin
        out_d = '{data_byte: acc_q, byte_valid: 1'b1, end_of_string: 1'b1,
                  string_bytes: cnt_inc, overflow: ovf_inc};
      end else begin
        out_d = '{data_byte: 8'd0, byte_valid: 1'b0, end_of_string: 1'b1,
                  string_bytes: cnt_q, overflow: ovf_q};
      end
      out_vld_d = 1'b1;
      acc_d     = '0;
      pend_d    = '0;
      cnt_d     = '0;
      ovf_d     = 1'b0;
    end else begin
      out_vld_d = out_vld_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      pend_q    <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign ready_o     = room;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_req_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.bit_vld && req_i.flush))
    else $error("bit and flush requested together");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.end_of_string |-> out_q.string_bytes <= MaxB)
    else $error("string byte count above saturation limit");

  a_plain_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.end_of_string |->
      out_q.byte_valid && out_q.string_bytes == 8'd0 && !out_q.overflow)
    else $error("mid-string result carries end fields");

endmodule

// ===== design/context_huffman_string_encoder_core.sv =====
// ----------------------------------------------------------------------------
// context_huffman_string_encoder_core
// order-1 context huffman encoder: link memory walk, bit packing, end marker
// ----------------------------------------------------------------------------
// After reset the block sweeps the link memory to "no parent", one entry per
// cycle over all NUM_SYMBOLS*NODES_PER_TREE entries (131072 by default), and
// accepts no transaction until done. An encode transaction whose symbol is
// zero also ends the string with a flush, and output stalls hold the encode:
// the walk reads one link per cycle from the single-port-read link memory, and
// the path bits leave the path register one per cycle into the byte packer
// while the packer is ready. Items are worked one at a time; a finished byte
// waits in the output register while work goes on.
// ----------------------------------------------------------------------------
module context_huffman_string_encoder_core #(
  parameter int NUM_SYMBOLS      = chse_pkg::NumSymbolsDef,
  parameter int NODES_PER_TREE   = chse_pkg::NodesPerTreeDef,
  parameter int MAX_STRING_BYTES = chse_pkg::MaxStringBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  chse_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output chse_pkg::out_item_t out_data_o
);
  import chse_pkg::*;

  localparam int Depth   = NUM_SYMBOLS * NODES_PER_TREE;
  localparam int AW      = $clog2(Depth);
  localparam int MaxPath = NUM_SYMBOLS - 1;
  localparam int LW      = $clog2(NUM_SYMBOLS);

  localparam logic [AW-1:0]    LastAddr = AW'(Depth - 1);
  localparam logic [AW-1:0]    NptA     = AW'(NODES_PER_TREE);
  localparam logic [8:0]       NumSymW  = 9'(NUM_SYMBOLS);
  localparam logic [9:0]       NptW     = 10'(NODES_PER_TREE);
  localparam logic [LW-1:0]    MaxLen   = LW'(MaxPath);

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [7:0]          prev_q, prev_d;
  logic                zero_q, zero_d;
  logic [LW-1:0]       len_q, len_d;
  logic [AW-1:0]       base_q, base_d;
  logic [MaxPath-1:0]  path_q, path_d;

  logic                accept;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [LinkW-1:0]    mem_wdata, mem_rdata;
  logic [8:0]          link_parent;
  logic                link_right;
  logic                link_ok;
  logic                load_ok, enc_ok;
  logic [AW-1:0]       enc_base;
  pk_req_t             pk_req;
  logic                pk_ready;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign link_parent = mem_rdata[8:0];
  assign link_right  = mem_rdata[9];
  assign link_ok     = (link_parent != NoParent) && ({1'b0, link_parent} < NptW);
  assign load_ok     = ({1'b0, in_data_i.ctx} < NumSymW) &&
                       ({1'b0, in_data_i.node_index} < NptW);
  assign enc_ok      = ({1'b0, in_data_i.symbol} < NumSymW) &&
                       ({1'b0, prev_q} < NumSymW);
  assign enc_base    = AW'(AW'(prev_q) * NptA);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    prev_d    = prev_q;
    zero_d    = zero_q;
    len_d     = len_q;
    base_d    = base_q;
    path_d    = path_q;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = LinkW'(NoParent);
    mem_re    = 1'b0;
    mem_raddr = base_q + AW'(link_parent);
    pk_req    = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.op == OpLoad) begin
            mem_we    = load_ok;
            mem_waddr = AW'(AW'(in_data_i.ctx) * NptA) + AW'(in_data_i.node_index);
            mem_wdata = {in_data_i.right_child, in_data_i.parent_index};
          end else begin
            prev_d = in_data_i.symbol;
            zero_d = (in_data_i.symbol == 8'd0);
            if (enc_ok) begin
              mem_re    = 1'b1;
              mem_raddr = enc_base + AW'(in_data_i.symbol);
              base_d    = enc_base;
              len_d     = '0;
              state_d   = ST_WALK;
            end else if (in_data_i.symbol == 8'd0) begin
              state_d = ST_FLUSH;
            end
          end
        end
      end
      ST_WALK: begin
        if (link_ok && (len_q != MaxLen)) begin
          path_d = (path_q << 1) | MaxPath'(link_right);
          len_d  = len_q + LW'(1);
          mem_re = 1'b1;
        end else if (len_q != '0) begin
          state_d = ST_POP;
        end else if (zero_q) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        pk_req.bit_vld = 1'b1;
        pk_req.bit_val = path_q[0];
        if (pk_ready) begin
          path_d = path_q >> 1;
          len_d  = len_q - LW'(1);
          if (len_q == LW'(1)) begin
            state_d = zero_q ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        pk_req.flush = 1'b1;
        if (pk_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      prev_q  <= '0;
      zero_q  <= 1'b0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      prev_q  <= prev_d;
      zero_q  <= zero_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    path_q <= path_d;
  end

  chse_link_mem #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  chse_packer #(
    .MAX_STRING_BYTES (MAX_STRING_BYTES)
  ) u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (pk_req),
    .ready_o     (pk_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> (len_q != '0))
    else $error("popping an empty path");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_POP || state_q == ST_FLUSH) |-> !mem_we)
    else $error("link memory written during encode");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && $past(state_q) == ST_CLEAR) |-> $past(clr_q) == LastAddr)
    else $error("clearing sweep ended early");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |=> (len_q <= MaxLen))
    else $error("path longer than the deepest tree");

endmodule
